// ----- sv/hlpsp_pkg.sv -----
package hlpsp_pkg;

  localparam int unsigned LineLen = 13;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [3:0] HAT_MAX = 4'd8;

  // fixed column layout of one line
  localparam logic [3:0] POS_BTN     = 4'd0;
  localparam logic [3:0] POS_BTN_END = 4'd3;
  localparam logic [3:0] POS_HAT     = 4'd4;
  localparam logic [3:0] POS_LX      = 4'd5;
  localparam logic [3:0] POS_LX_END  = 4'd6;
  localparam logic [3:0] POS_LY      = 4'd7;
  localparam logic [3:0] POS_LY_END  = 4'd8;
  localparam logic [3:0] POS_RX      = 4'd9;
  localparam logic [3:0] POS_RX_END  = 4'd10;
  localparam logic [3:0] POS_RY      = 4'd11;
  localparam logic [3:0] POS_LAST    = 4'd12;

  typedef struct packed {
    logic       vld;
    logic [3:0] pos;
  } step_t;

  typedef struct packed {
    logic [13:0] buttons;
    logic [3:0]  hat;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
  } res_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [3:0] hat_clamp(input logic [7:0] c);
    logic [3:0] r;
    if (c[7] || c <= CH_ZERO) begin
      r = 4'd0;
    end else if (c >= 8'h38) begin
      r = HAT_MAX;
    end else begin
      r = c[3:0];
    end
    return r;
  endfunction

endpackage

// ----- sv/hex_line_pad_state_parser_top.sv -----
// Ordinary bytes are taken one per cycle in the idle state; in_stall stays low between them.
// A carriage return walks the 13-entry line memory, one read per cycle,
// and, once the walk, the drain state and the final state are through, shows its beat on out_*.
// The result register lets new bytes in while a finished beat waits on out_stall.
// Synchronous active-low reset empties the line (fill count zero) and drops out_valid.
module hex_line_pad_state_parser_top import hlpsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_buttons,
  output logic [3:0]  out_hat,
  output logic [7:0]  out_left_x,
  output logic [7:0]  out_left_y,
  output logic [7:0]  out_right_x,
  output logic [7:0]  out_right_y
);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_FIN} state_t;

  state_t      state_r;
  logic [3:0]  fill_cnt_r;
  logic [3:0]  rd_addr_r;
  logic [7:0]  rd_data_r;
  step_t       step_r;
  logic        out_valid_r;
  res_t        out_r;
  res_t        res;

  logic [7:0]  mem [LineLen];

  logic        in_acc;
  logic        is_cr;
  logic        wr_en;
  logic        out_free;
  logic [7:0]  ch;

  assign in_acc   = in_valid && !in_stall;
  assign is_cr    = in_rx_byte == CH_CR;
  assign wr_en    = in_acc && !is_cr && in_rx_byte != CH_LF && fill_cnt_r < 4'(LineLen);
  assign out_free = !out_valid_r || !out_stall;
  // positions never written since the last line end read as zero
  assign ch       = (step_r.pos < fill_cnt_r) ? rd_data_r : 8'd0;
  assign in_stall = state_r != ST_IDLE;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_cnt_r] <= in_rx_byte;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_cnt_r  <= 4'd0;
      rd_addr_r   <= 4'd0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r.vld <= state_r == ST_WALK;
      step_r.pos <= rd_addr_r;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          rd_addr_r <= 4'd0;
          if (wr_en) begin
            fill_cnt_r <= fill_cnt_r + 4'd1;
          end
          if (in_acc && is_cr) begin
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (rd_addr_r == POS_LAST) begin
            state_r <= ST_DRAIN;
          end else begin
            rd_addr_r <= rd_addr_r + 4'd1;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            out_r      <= res;
            fill_cnt_r <= 4'd0;
            state_r    <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  hlpsp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step_r),
    .ch    (ch),
    .res   (res)
  );

  assign out_valid   = out_valid_r;
  assign out_buttons = out_r.buttons;
  assign out_hat     = out_r.hat;
  assign out_left_x  = out_r.left_x;
  assign out_left_y  = out_r.left_y;
  assign out_right_x = out_r.right_x;
  assign out_right_y = out_r.right_y;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= 4'(LineLen))
    else $error("fill count past line length");

  a_cr_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_rx_byte == CH_CR |=> state_r == ST_WALK && rd_addr_r == 4'd0)
    else $error("carriage return did not start walk");

  a_step_pos: assert property (@(posedge clk) disable iff (!rst_n)
    step_r.vld |-> step_r.pos <= POS_LAST)
    else $error("walk position out of range");

  a_hat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.hat <= HAT_MAX)
    else $error("hat out of range");

endmodule

// ----- sv/hlpsp_scan.sv -----
module hlpsp_scan import hlpsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  step_t      step,
  input  logic [7:0] ch,
  output res_t       res
);

  logic        skip_r, skip_nxt;
  logic        stop_r, stop_nxt;
  logic [13:0] acc_r, acc_nxt;
  res_t        res_r;

  logic        first;
  logic        skip, stop;
  logic [13:0] acc;
  logic [4:0]  dig;

  always_comb begin
    first    = step.pos inside {POS_BTN, POS_LX, POS_LY, POS_RX, POS_RY};
    skip     = first | skip_r;
    stop     = !first & stop_r;
    acc      = first ? 14'd0 : acc_r;
    dig      = hex_digit(ch);
    skip_nxt = skip;
    stop_nxt = stop;
    acc_nxt  = acc;
    if (!stop && !(skip && ch == CH_SPACE)) begin
      if (dig[4]) begin
        acc_nxt  = {acc[9:0], dig[3:0]};
        skip_nxt = 1'b0;
      end else begin
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b0;
      stop_r <= 1'b0;
    end else if (step.vld) begin
      skip_r <= skip_nxt;
      stop_r <= stop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.vld) begin
      acc_r <= acc_nxt;
      case (step.pos)
        POS_BTN_END: res_r.buttons <= acc_nxt;
        POS_HAT:     res_r.hat     <= hat_clamp(ch);
        POS_LX_END:  res_r.left_x  <= acc_nxt[7:0];
        POS_LY_END:  res_r.left_y  <= acc_nxt[7:0];
        POS_RX_END:  res_r.right_x <= acc_nxt[7:0];
        POS_LAST:    res_r.right_y <= acc_nxt[7:0];
        default: ;
      endcase
    end
  end

  assign res = res_r;

endmodule

// ----- sim/tb_hex_line_pad_state_parser_top.sv -----
`timescale 1ns / 1ps

module tb_hex_line_pad_state_parser_top;
  import hlpsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_BYTES  = 1700;
  localparam int unsigned TAIL_BYTES  = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 40;

  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } rx_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_buttons;
  logic [3:0]  out_hat;
  logic [7:0]  out_left_x;
  logic [7:0]  out_left_y;
  logic [7:0]  out_right_x;
  logic [7:0]  out_right_y;

  hex_line_pad_state_parser_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_buttons (out_buttons),
    .out_hat     (out_hat),
    .out_left_x  (out_left_x),
    .out_left_y  (out_left_y),
    .out_right_x (out_right_x),
    .out_right_y (out_right_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rx_beat_t    rx_q[$];
  res_t        pad_state_q[$];
  logic [7:0]  line_chars[LineLen];
  int unsigned line_fill;

  int unsigned n_total;
  int unsigned bytes_sent;
  int unsigned lines_seen;
  int unsigned errors;
  int unsigned cycles;
  int unsigned backpressure_cycles;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned hold_cnt;
  bit          held;
  res_t        got_state;

  string hex_chars = "0123456789abcdefABCDEF";

  // -------- line predictor --------
  function automatic int nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic logic [31:0] hex_field(int start, int len);
    logic [31:0] acc;
    int i;
    int d;
    acc = '0;
    i = 0;
    while (i < len && line_chars[start + i] == CH_SPACE) i++;
    while (i < len) begin
      d = nibble(line_chars[start + i]);
      if (d < 0) break;
      acc = (acc << 4) | 32'(d);
      i++;
    end
    return acc;
  endfunction

  // high bytes behave as negative chars, so they clamp to zero
  function automatic logic [3:0] hat_of(logic [7:0] c);
    if (c >= 8'h80 || c <= CH_ZERO) return 4'd0;
    if (c >= 8'h38) return HAT_MAX;
    return 4'(c - CH_ZERO);
  endfunction

  task automatic take_byte(logic [7:0] c);
    res_t r;
    if (c == CH_CR) begin
      r.buttons = 14'(hex_field(0, 4));
      r.hat     = hat_of(line_chars[4]);
      r.left_x  = 8'(hex_field(5, 2));
      r.left_y  = 8'(hex_field(7, 2));
      r.right_x = 8'(hex_field(9, 2));
      r.right_y = 8'(hex_field(11, 2));
      pad_state_q.push_back(r);
      for (int i = 0; i < LineLen; i++) line_chars[i] = 8'h00;
      line_fill = 0;
    end else if (c != CH_LF && line_fill < LineLen) begin
      line_chars[line_fill] = c;
      line_fill++;
    end
  endtask

  // -------- stimulus builders --------
  task automatic queue_str(string s);
    for (int i = 0; i < s.len(); i++) rx_q.push_back('{s[i], 1'b0});
  endtask

  function automatic logic [7:0] field_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 68) return hex_chars[$urandom_range(0, 21)];
    if (r < 80) return CH_SPACE;
    if (r < 84) return 8'h00;
    if (r < 88) return (r[0]) ? "-" : "x";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hat_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'(CH_ZERO + $urandom_range(0, 8));
    if (r < 80) return 8'($urandom_range(8'h29, 8'h3F));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_line(bit drain_first);
    int r;
    int len;
    r = $urandom_range(0, 99);
    len = (r < 75) ? 13 : (r < 88) ? $urandom_range(0, 12) : $urandom_range(14, 18);
    for (int p = 0; p < len; p++) begin
      rx_q.push_back('{(p == 4) ? hat_char() : field_char(), drain_first && p == 0});
      if ($urandom_range(0, 29) == 0) rx_q.push_back('{CH_LF, 1'b0});
    end
    rx_q.push_back('{CH_CR, drain_first && len == 0});
  endtask

  // idling pattern changes every 128 beats: none, light, heavy
  function automatic bit go_idle();
    int unsigned mode;
    mode = (bytes_sent / 128) % 3;
    if (bytes_sent + TAIL_BYTES >= n_total || mode == 0) return 1'b0;
    return $urandom_range(0, (mode == 1) ? 9 : 2) == 0;
  endfunction

  // -------- driver --------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(in_rx_byte);
        bytes_sent++;
      end
      if (in_valid && in_stall) backpressure_cycles++;
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (rx_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (rx_q[0].drain && pad_state_q.size() != 0) begin
          in_valid <= 1'b0;
        end else if (go_idle()) begin
          tx_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          in_rx_byte <= rx_q[0].ch;
          in_valid   <= 1'b1;
          rx_q.pop_front();
        end
      end
    end
  end

  // -------- receiver stall --------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (!held && lines_seen >= 60) begin
      // long hold-off so the result register and the input side back up
      held = 1'b1;
      hold_cnt = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (go_idle()) begin
      rx_gap = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // -------- monitor --------
  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pad_state_q.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with no line pending, expected none, actual %h",
                 $time, {out_buttons, out_hat, out_left_x, out_left_y, out_right_x,
                 out_right_y});
      end else begin
        got_state = pad_state_q.pop_front();
        check_field("buttons", got_state.buttons, out_buttons);
        check_field("hat",     got_state.hat,     out_hat);
        check_field("left_x",  got_state.left_x,  out_left_x);
        check_field("left_y",  got_state.left_y,  out_left_y);
        check_field("right_x", got_state.right_x, out_right_x);
        check_field("right_y", got_state.right_y, out_right_y);
        lines_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines still pending", cycles, pad_state_q.size());
      $display("** hex_line_pad_state_parser_top: FAILED **");
      $finish;
    end
  end

  // -------- sequence --------
  initial begin
    int unsigned n_lines;
    for (int i = 0; i < LineLen; i++) line_chars[i] = 8'h00;
    // empty line straight out of reset
    rx_q.push_back('{CH_CR, 1'b0});
    // all-max fields, hat above 8, one byte past a full line
    queue_str("FFFF9FFFFFFFF7");
    rx_q.push_back('{CH_CR, 1'b0});
    // leading space, lowercase, line feed, high hat byte, sign, 0x prefix, short line
    queue_str(" 3a\ng");
    rx_q.push_back('{8'hB5, 1'b0});
    queue_str(" C-10x");
    rx_q.push_back('{CH_CR, 1'b0});
    n_lines = 0;
    while (rx_q.size() < RAND_BYTES) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6)) rx_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
      end else begin
        queue_line(n_lines == 30 || n_lines == 90);
        n_lines++;
      end
    end
    n_total = rx_q.size();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (rx_q.size() != 0 || in_valid || pad_state_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d bytes, checked %0d parsed lines, input held off for %0d cycles",
             bytes_sent, lines_seen, backpressure_cycles);
    if (errors == 0) begin
      $display("** hex_line_pad_state_parser_top: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** hex_line_pad_state_parser_top: FAILED **");
    end
    $finish;
  end

endmodule
